FILE: src/mhpq_pkg.sv
// Shared types and codes for the min-heap priority queue.
`timescale 1ns / 1ps
package mhpq_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CountW  = 6;
  localparam int unsigned StatusW = 2;

  localparam logic [CmdW-1:0] CmdPush = 2'd0;
  localparam logic [CmdW-1:0] CmdPop  = 2'd1;
  localparam logic [CmdW-1:0] CmdPeek = 2'd2;

  localparam logic [StatusW-1:0] StatOk    = 2'd0;
  localparam logic [StatusW-1:0] StatFull  = 2'd1;
  localparam logic [StatusW-1:0] StatEmpty = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

FILE: src/mhpq_cell.sv
// One slot of the sorted cell row: holds a value, shifts on push and pop.
`timescale 1ns / 1ps
module mhpq_cell
  import mhpq_pkg::*;
(
  input  logic                   clk_i,
  input  cell_ctl_t              ctl_i,
  input  logic signed [ValW-1:0] value_i,
  input  logic                   occ_i,
  input  logic signed [ValW-1:0] left_val_i,
  input  logic                   left_go_i,
  input  logic signed [ValW-1:0] right_val_i,
  output logic signed [ValW-1:0] val_o,
  output logic                   go_o
);

  logic signed [ValW-1:0] val_q, val_d;

  // new value belongs at or before this slot
  assign go_o  = !occ_i || (value_i < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.push) begin
      if (left_go_i) begin
        val_d = left_val_i;
      end else if (go_o) begin
        val_d = value_i;
      end
    end else if (ctl_i.pop) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: src/min_heap_priority_queue.sv
// Top level: bounded min priority queue built as a sorted row of cells.
// Latency: result valid in the cycle after the item is accepted.
// One item in flight: a new item is accepted only after the previous result has been taken.
// Push and pop each complete in a single shift of the cell row; peek leaves the row unchanged.
// Reset clears the entry count and the result register; cell contents stay undefined.
`timescale 1ns / 1ps
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 63
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CmdW-1:0]           command_i,
  input  logic signed [ValW-1:0]    value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ValW-1:0]    minimum_o,
  output logic [CountW-1:0]         count_o,
  output logic                      empty_res_o,
  output logic [StatusW-1:0]        status_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  logic               accept;
  logic               full, empty;
  cell_ctl_t          ctl;

  logic signed [ValW-1:0] vals [CAPACITY];
  logic                   gos  [CAPACITY];

  assign accept = in_valid_i && !in_stall_o;
  assign full   = (count_q == CW'(CAPACITY));
  assign empty  = (count_q == '0);

  always_comb begin
    ctl      = '0;
    count_d  = count_q;
    status_d = StatOk;
    case (command_i)
      CmdPush: begin
        if (full) begin
          status_d = StatFull;
        end else begin
          ctl.push = accept;
          count_d  = count_q + 1'b1;
        end
      end
      CmdPop: begin
        if (empty) begin
          status_d = StatEmpty;
        end else begin
          ctl.pop = accept;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValW-1:0] left_val, right_val;
    logic                   left_go, occ;
    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_go  = 1'b0;
    end else begin : g_mid
      assign left_val = vals[i-1];
      assign left_go  = gos[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end
    assign occ = (count_q > CW'(i));

    mhpq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .value_i     (value_i),
      .occ_i       (occ),
      .left_val_i  (left_val),
      .left_go_i   (left_go),
      .right_val_i (right_val),
      .val_o       (vals[i]),
      .go_o        (gos[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StatOk;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = out_valid_q;
  assign out_valid_o = out_valid_q;
  assign minimum_o   = empty ? '0 : vals[0];
  assign count_o     = CountW'(count_q);
  assign empty_res_o = empty;
  assign status_o    = status_q;

endmodule

FILE: src/mhpq_chk.sv
// Port-level checks for the priority queue, bound to the top level.
`timescale 1ns / 1ps
module mhpq_chk
  import mhpq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [CmdW-1:0]        command_i,
  input logic signed [ValW-1:0] value_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [ValW-1:0] minimum_o,
  input logic [CountW-1:0]      count_o,
  input logic                   empty_res_o,
  input logic [StatusW-1:0]     status_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("no result after accepted item");

  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> (minimum_o == '0 && count_o == '0))
    else $error("empty queue reports entries");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StatEmpty) |-> empty_res_o)
    else $error("underflow on non-empty queue");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind min_heap_priority_queue mhpq_chk u_mhpq_chk (.*);
